// File: rtl/pidc_pkg.sv
package pidc_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 48;
    localparam int FRAC_W = 16;
    localparam int RATE_W = DATA_W - 1;
    localparam int HALF_W = ACC_W / 2;
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MAC_W  = DATA_W + ACC_W;
    localparam int TERM_W = 64;
    localparam int IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP_TIME = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP_RATE = 3'd4;
    localparam logic [IDX_W-1:0] REG_OUT_MAX   = 3'd5;
    localparam logic [IDX_W-1:0] REG_OUT_MIN   = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_T,
        ST_INTEG,
        ST_MUL_IL,
        ST_MUL_IH,
        ST_MUL_R,
        ST_DERIV,
        ST_MUL_DL,
        ST_MUL_DH,
        ST_SUM,
        ST_DONE
    } pidc_state_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ACC_HI
    } mac_op_t;

    typedef enum logic [2:0] {
        A_GAIN_P,
        A_GAIN_I,
        A_GAIN_D,
        A_ERROR,
        A_DIFF
    } a_sel_t;

    typedef enum logic [2:0] {
        B_ERROR,
        B_STEP_TIME,
        B_STEP_RATE,
        B_INT_LO,
        B_INT_HI,
        B_HOLD_LO,
        B_HOLD_HI
    } b_sel_t;

    typedef struct packed {
        logic    in_ready;
        logic    ld_err;
        mac_op_t mac_op;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        logic    ld_hold;
        logic    ld_integ;
        logic    ld_sum_i;
        logic    ld_sum_d;
        logic    ld_out;
    } pidc_ctrl_t;

    // Q16.16 product scaling: drop the fraction bits, rounding toward zero.
    function automatic logic signed [TERM_W-1:0] qtrunc(input logic signed [MAC_W-1:0] v);
        logic signed [MAC_W-1:0] adj;
        adj = v + (v[MAC_W-1] ? MAC_W'((1 << FRAC_W) - 1) : MAC_W'(0));
        return TERM_W'(adj >>> FRAC_W);
    endfunction

endpackage

// File: rtl/pidc_mac.sv
module pidc_mac
    import pidc_pkg::*;
(
    input  logic                     clk,
    input  mac_op_t                  op,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [MAC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod;
    logic signed [MAC_W-1:0]  acc_reg;
    logic signed [MAC_W-1:0]  acc_next;

    assign prod = a * b;

    // The high partial product of a split wide operand lands HALF_W bits up.
    always_comb
    begin
        unique case (op)
            MAC_LOAD:   acc_next = MAC_W'(prod);
            MAC_ACC_HI: acc_next = acc_reg + (MAC_W'(prod) <<< HALF_W);
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: rtl/pidc_seq.sv
module pidc_seq
    import pidc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_free,
    output pidc_ctrl_t ctrl
);

    pidc_state_t state_reg;
    pidc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        ctrl.mac_op   = MAC_HOLD;
        ctrl.a_sel    = A_GAIN_P;
        ctrl.b_sel    = B_ERROR;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.ld_err = 1'b1;
                    state_next  = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                ctrl.mac_op = MAC_LOAD;
                ctrl.a_sel  = A_GAIN_P;
                ctrl.b_sel  = B_ERROR;
                state_next  = ST_MUL_T;
            end
            ST_MUL_T:
            begin
                ctrl.ld_hold = 1'b1;
                ctrl.mac_op  = MAC_LOAD;
                ctrl.a_sel   = A_ERROR;
                ctrl.b_sel   = B_STEP_TIME;
                state_next   = ST_INTEG;
            end
            ST_INTEG:
            begin
                ctrl.ld_integ = 1'b1;
                state_next    = ST_MUL_IL;
            end
            ST_MUL_IL:
            begin
                ctrl.mac_op = MAC_LOAD;
                ctrl.a_sel  = A_GAIN_I;
                ctrl.b_sel  = B_INT_LO;
                state_next  = ST_MUL_IH;
            end
            ST_MUL_IH:
            begin
                ctrl.mac_op = MAC_ACC_HI;
                ctrl.a_sel  = A_GAIN_I;
                ctrl.b_sel  = B_INT_HI;
                state_next  = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                ctrl.ld_sum_i = 1'b1;
                ctrl.mac_op   = MAC_LOAD;
                ctrl.a_sel    = A_DIFF;
                ctrl.b_sel    = B_STEP_RATE;
                state_next    = ST_DERIV;
            end
            ST_DERIV:
            begin
                ctrl.ld_hold = 1'b1;
                state_next   = ST_MUL_DL;
            end
            ST_MUL_DL:
            begin
                ctrl.mac_op = MAC_LOAD;
                ctrl.a_sel  = A_GAIN_D;
                ctrl.b_sel  = B_HOLD_LO;
                state_next  = ST_MUL_DH;
            end
            ST_MUL_DH:
            begin
                ctrl.mac_op = MAC_ACC_HI;
                ctrl.a_sel  = A_GAIN_D;
                ctrl.b_sel  = B_HOLD_HI;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                ctrl.ld_sum_d = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait here while the previous result is still unclaimed.
                if (out_free)
                begin
                    ctrl.ld_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pid_controller_clamped_core.sv
// Clamped PID controller, signed Q16.16 arithmetic.
// Requests arrive on the s_axis channel: tdata carries target in bits 31:0 and
// measured in bits 63:32. Each request yields exactly one result on m_axis,
// whose tdata is the clamped drive value.
// Gains, sample period, reciprocal period and the output limits are written
// through the cfg port (cfg_wr_en, cfg_index, cfg_data); the user must write
// them only while the block is idle, as the block itself does not enforce it.
// One shared 33x33 multiplier with an 80-bit accumulator computes all terms
// under a sequencer; the integral and derivative gain products are split into
// two partial products each. s_axis_tready is high only in the idle state:
// a new request waits until the previous one has gone through the seven
// multiplier passes and bookkeeping steps and its result has been loaded.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and worked on, and the sequencer waits at its last
// step until the output register is free.
// Reset clears the integral accumulator and the stored previous error, sets
// the gains to zero, period and rate to 1.0 and the limits to the full range.
module pid_controller_clamped_core
    import pidc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*DATA_W-1:0]  s_axis_tdata,   // target, measured
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // drive
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;
    logic [RATE_W-1:0]        step_time_reg;
    logic [RATE_W-1:0]        step_rate_reg;
    logic signed [DATA_W-1:0] out_max_reg;
    logic signed [DATA_W-1:0] out_min_reg;

    logic signed [ACC_W-1:0]  integ_reg;
    logic signed [ACC_W-1:0]  integ_next;
    logic signed [DATA_W-1:0] last_err_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] err_next;
    logic signed [ACC_W-1:0]  hold_reg;
    logic signed [TERM_W-1:0] sum_reg;
    logic signed [TERM_W-1:0] sum_next;
    logic signed [DATA_W-1:0] drive_reg;
    logic                     m_valid_reg;
    logic                     m_valid_next;

    pidc_ctrl_t               ctrl;
    logic                     out_free;
    logic signed [MUL_W-1:0]  mac_a;
    logic signed [MUL_W-1:0]  mac_b;
    logic signed [MAC_W-1:0]  mac_acc;
    logic signed [TERM_W-1:0] qt;
    logic signed [MUL_W-1:0]  diff;
    logic signed [MUL_W-1:0]  err_diff;
    logic signed [ACC_W:0]    integ_sum;
    logic signed [TERM_W-1:0] clamp_in;
    logic signed [DATA_W-1:0] clamp_val;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            step_time_reg <= RATE_W'(1 << FRAC_W);
            step_rate_reg <= RATE_W'(1 << FRAC_W);
            out_max_reg   <= {1'b0, {(DATA_W-1){1'b1}}};
            out_min_reg   <= {1'b1, {(DATA_W-1){1'b0}}};
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= cfg_data;
                REG_GAIN_I:    gain_i_reg    <= cfg_data;
                REG_GAIN_D:    gain_d_reg    <= cfg_data;
                REG_STEP_TIME: step_time_reg <= cfg_data[RATE_W-1:0];
                REG_STEP_RATE: step_rate_reg <= cfg_data[RATE_W-1:0];
                REG_OUT_MAX:   out_max_reg   <= cfg_data;
                REG_OUT_MIN:   out_min_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_axis_tready;

    pidc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    assign s_axis_tready = ctrl.in_ready;

    // Error, saturated to the data width.
    always_comb
    begin
        err_diff = MUL_W'($signed(s_axis_tdata[DATA_W-1:0]))
                 - MUL_W'($signed(s_axis_tdata[2*DATA_W-1:DATA_W]));
        if (err_diff[MUL_W-1] != err_diff[MUL_W-2])
        begin
            err_next = err_diff[MUL_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            err_next = err_diff[DATA_W-1:0];
        end
    end

    assign diff = MUL_W'(err_reg) - MUL_W'(last_err_reg);

    always_comb
    begin
        unique case (ctrl.a_sel)
            A_GAIN_P: mac_a = MUL_W'(gain_p_reg);
            A_GAIN_I: mac_a = MUL_W'(gain_i_reg);
            A_GAIN_D: mac_a = MUL_W'(gain_d_reg);
            A_ERROR:  mac_a = MUL_W'(err_reg);
            A_DIFF:   mac_a = diff;
            default:  mac_a = '0;
        endcase
    end

    // Wide operands are split into an unsigned low half and a signed high half.
    always_comb
    begin
        unique case (ctrl.b_sel)
            B_ERROR:     mac_b = MUL_W'(err_reg);
            B_STEP_TIME: mac_b = $signed(MUL_W'(step_time_reg));
            B_STEP_RATE: mac_b = $signed(MUL_W'(step_rate_reg));
            B_INT_LO:    mac_b = $signed(MUL_W'(integ_reg[HALF_W-1:0]));
            B_INT_HI:    mac_b = MUL_W'($signed(integ_reg[ACC_W-1:HALF_W]));
            B_HOLD_LO:   mac_b = $signed(MUL_W'(hold_reg[HALF_W-1:0]));
            B_HOLD_HI:   mac_b = MUL_W'($signed(hold_reg[ACC_W-1:HALF_W]));
            default:     mac_b = '0;
        endcase
    end

    pidc_mac u_mac (
        .clk (clk),
        .op  (ctrl.mac_op),
        .a   (mac_a),
        .b   (mac_b),
        .acc (mac_acc)
    );

    assign qt = qtrunc(mac_acc);

    // Integral update; the increment always fits in ACC_W bits.
    always_comb
    begin
        integ_sum = (ACC_W+1)'(integ_reg) + (ACC_W+1)'(qt);
        if (integ_sum[ACC_W] != integ_sum[ACC_W-1])
        begin
            integ_next = integ_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            integ_next = integ_sum[ACC_W-1:0];
        end
    end

    // One limiter, shared by the integral term and the final sum.
    always_comb
    begin
        clamp_in = ctrl.ld_sum_i ? qt : sum_reg;
        priority if (clamp_in > TERM_W'(out_max_reg))
        begin
            clamp_val = out_max_reg;
        end
        else if (clamp_in < TERM_W'(out_min_reg))
        begin
            clamp_val = out_min_reg;
        end
        else
        begin
            clamp_val = clamp_in[DATA_W-1:0];
        end
    end

    // The P, I and D terms are bounded well inside 64 bits, so plain adds suffice.
    always_comb
    begin
        if (ctrl.ld_sum_i)
        begin
            sum_next = TERM_W'(hold_reg) + TERM_W'(clamp_val);
        end
        else
        begin
            sum_next = sum_reg + qt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            if (ctrl.ld_integ)
            begin
                integ_reg <= integ_next;
            end
            if (ctrl.ld_out)
            begin
                last_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_err)
        begin
            err_reg <= err_next;
        end
        if (ctrl.ld_hold)
        begin
            hold_reg <= qt[ACC_W-1:0];
        end
        if (ctrl.ld_sum_i || ctrl.ld_sum_d)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.ld_out)
        begin
            drive_reg <= clamp_val;
        end
    end

    assign m_valid_next = ctrl.ld_out || (m_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = drive_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while a previous one is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ld_out |-> (!m_valid_reg || m_axis_tready))
    else $error("result register overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(ctrl.ld_out))
    else $error("result appeared without a completed computation");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ld_out |=> s_axis_tready)
    else $error("sequencer did not return to idle after delivering a result");

endmodule
